// ===== rtl/lru_pkg.sv =====
// Shared types and constants for the LRU slot allocator.
// No dependencies; imported by lru_slot_allocator.
`default_nettype none

package lru_pkg;

    localparam int SLOTS  = 64;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int SLOT_W = 6;
    localparam int TS_W   = 32;
    localparam int CNT_W  = 7;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_TOUCH = 2'd1,
        KIND_FREE  = 2'd2,
        KIND_NOP   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [SLOT_W-1:0]   slot;
        logic [TS_W-1:0]     timestamp;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0]   granted_slot;
        logic                evicted;
        logic [CNT_W-1:0]    free_count;
        logic                error;
    } t_rsp;

endpackage

`default_nettype wire

// ===== rtl/lru_ts_ram.sv =====
// Simple dual-port RAM: one write port, one read port, registered read data.
// Standalone; holds the per-slot last-use timestamps.
`default_nettype none

module lru_ts_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/lru_slot_allocator.sv =====
// LRU slot allocator top level: request sequencer, in-use flags and free count.
// Depends on lru_pkg and lru_ts_ram (last-use timestamp memory).
//
// A request transaction is taken on a rising edge with start high and busy
// low; busy then stays high until the answer has been produced. Every request
// yields exactly one response, shown on o_rsp for a single cycle with o_valid
// high; there is no back-pressure, so the receiver must capture it on that
// edge. Touch, free and no-op are answered from ST_OP. An alloc with a free
// slot walks the in-use flags one slot per cycle up to the lowest free slot;
// an alloc on a full pool streams the timestamp memory's single read port,
// one entry per cycle, into the running-minimum compare. busy drops on the
// same edge that raises o_valid, so a new request can be taken on the next
// edge. No clearing pass after reset: the in-use flags reset in flops and
// the timestamp memory is only read when every slot has been stamped.
`default_nettype none

module lru_slot_allocator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  lru_pkg::t_req i_req,
    output logic          busy,
    output logic          o_valid,
    output lru_pkg::t_rsp o_rsp
);

    import lru_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OP,
        ST_FIND,
        ST_SCAN
    } t_state;

    t_state            r_state;
    t_req              r_req;
    t_rsp              r_rsp;
    logic              r_valid;
    logic [SLOTS-1:0]  r_in_use;
    logic [CNT_W-1:0]  r_free;
    logic [IDX_W-1:0]  r_idx;       // walk / read address
    logic [IDX_W-1:0]  r_cmp_idx;   // slot whose timestamp is on rd_data
    logic              r_cmp_v;
    logic [IDX_W-1:0]  r_best;
    logic [TS_W-1:0]   r_best_ts;

    logic [IDX_W-1:0]  use_addr;
    logic              use_bit;
    logic              slot_ok;
    logic [TS_W-1:0]   rd_data;
    logic              cmp_take;
    logic [IDX_W-1:0]  n_best;
    logic [TS_W-1:0]   n_best_ts;
    logic              scan_last;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;

    // Single read of the in-use flags: walk index while searching, else
    // the requested slot.
    assign use_addr = (r_state == ST_FIND) ? r_idx : r_req.slot[IDX_W-1:0];
    assign use_bit  = r_in_use[use_addr];
    assign slot_ok  = (32'(r_req.slot) < SLOTS);

    // Running minimum: strict less-than keeps the lowest index on ties;
    // slot 0 seeds the minimum.
    assign cmp_take  = (r_cmp_idx == '0) || (rd_data < r_best_ts);
    assign n_best    = cmp_take ? r_cmp_idx : r_best;
    assign n_best_ts = cmp_take ? rd_data : r_best_ts;
    assign scan_last = r_cmp_v && (r_cmp_idx == IDX_W'(SLOTS - 1));

    // Timestamp writes: touch of a used slot, alloc into a free slot,
    // or restamp of the evicted slot at the end of the scan.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_req.slot[IDX_W-1:0];
        case (r_state)
            ST_OP: begin
                mem_we = (r_req.kind == KIND_TOUCH) && slot_ok && use_bit;
            end
            ST_FIND: begin
                mem_we    = !use_bit;
                mem_waddr = r_idx;
            end
            ST_SCAN: begin
                mem_we    = scan_last;
                mem_waddr = n_best;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    lru_ts_ram #(
        .DEPTH (SLOTS),
        .WIDTH (TS_W)
    ) u_ts_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_req.timestamp),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= 1'b0;
            r_in_use <= '0;
            r_free   <= CNT_W'(SLOTS);
            r_cmp_v  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_req   <= i_req;
                        r_idx   <= '0;
                        r_cmp_v <= 1'b0;
                        if (i_req.kind == KIND_ALLOC) begin
                            r_state <= (r_free != '0) ? ST_FIND : ST_SCAN;
                        end else begin
                            r_state <= ST_OP;
                        end
                    end
                end
                ST_OP: begin
                    r_rsp.granted_slot <= r_req.slot;
                    r_rsp.evicted      <= 1'b0;
                    r_rsp.error        <= 1'b0;
                    r_rsp.free_count   <= r_free;
                    if (r_req.kind == KIND_TOUCH || r_req.kind == KIND_FREE) begin
                        if (!(slot_ok && use_bit)) begin
                            r_rsp.error <= 1'b1;
                        end else if (r_req.kind == KIND_FREE) begin
                            r_in_use[use_addr] <= 1'b0;
                            r_free             <= r_free + CNT_W'(1);
                            r_rsp.free_count   <= r_free + CNT_W'(1);
                        end
                    end
                    r_valid <= 1'b1;
                    r_state <= ST_IDLE;
                end
                ST_FIND: begin
                    if (!use_bit) begin
                        r_in_use[use_addr] <= 1'b1;
                        r_free             <= r_free - CNT_W'(1);
                        r_rsp.granted_slot <= SLOT_W'(r_idx);
                        r_rsp.evicted      <= 1'b0;
                        r_rsp.error        <= 1'b0;
                        r_rsp.free_count   <= r_free - CNT_W'(1);
                        r_valid            <= 1'b1;
                        r_state            <= ST_IDLE;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                ST_SCAN: begin
                    // read pipeline: address r_idx now, registered data on the next cycle
                    r_idx     <= r_idx + IDX_W'(1);
                    r_cmp_idx <= r_idx;
                    r_cmp_v   <= 1'b1;
                    if (r_cmp_v) begin
                        r_best    <= n_best;
                        r_best_ts <= n_best_ts;
                    end
                    if (scan_last) begin
                        r_rsp.granted_slot <= SLOT_W'(n_best);
                        r_rsp.evicted      <= 1'b1;
                        r_rsp.error        <= 1'b0;
                        r_rsp.free_count   <= r_free;
                        r_valid            <= 1'b1;
                        r_cmp_v            <= 1'b0;
                        r_state            <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // Free count always matches the number of cleared in-use flags.
    a_count_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'($countones(r_in_use)) + 32'(r_free)) == SLOTS)
        else $error("free count out of step with in-use flags");

    // A response only follows a cycle of work.
    a_rsp_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("response without a request in flight");

    // Eviction only happens on a full pool.
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.evicted) |-> (o_rsp.free_count == '0))
        else $error("eviction with free slots left");

    // Eviction and error never occur together.
    a_evict_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_rsp.evicted && o_rsp.error))
        else $error("eviction flagged with error");

endmodule

`default_nettype wire

// ===== tb/sv/lru_checker.sv =====
// Response checker for lru_slot_allocator: predicts each response from the accepted
// request transactions and compares it field by field. Depends on lru_pkg.
module lru_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  lru_pkg::t_req i_req,
    input  logic          i_valid,
    input  lru_pkg::t_rsp i_rsp,
    output int            o_pending,
    output int            o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import lru_pkg::*;

    logic [SLOTS-1:0] in_use;
    logic [TS_W-1:0]  last_use [SLOTS];
    int               free_slots;
    t_rsp             rsp_due [$];
    t_rsp             want;
    int               fail_count = 0;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    task automatic report(string what, int got, int exp_val);
        if (fail_count < 50) begin
            $display("%0t lru_checker: %s got %0d want %0d", $time, what, got, exp_val);
        end
        fail_count++;
    endtask

    task automatic clear_pool();
        int idx;
        in_use = '0;
        for (idx = 0; idx < SLOTS; idx++) begin
            last_use[idx] = '0;
        end
        free_slots = SLOTS;
    endtask

    // Applies one request to the pool image and returns the response it causes.
    function automatic t_rsp apply_request(t_req r);
        t_rsp rsp;
        int   idx;
        int   best;
        logic found;
        rsp.granted_slot = r.slot;
        rsp.evicted      = 1'b0;
        rsp.error        = 1'b0;
        case (r.kind)
            KIND_ALLOC: begin
                found = 1'b0;
                for (idx = 0; idx < SLOTS && !found; idx++) begin
                    if (!in_use[idx]) begin
                        in_use[idx]   = 1'b1;
                        last_use[idx] = r.timestamp;
                        if (free_slots > 0) begin
                            free_slots--;
                        end
                        rsp.granted_slot = SLOT_W'(idx);
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    // full pool: oldest stamp goes, lowest index on a tie
                    best = 0;
                    for (idx = 1; idx < SLOTS; idx++) begin
                        if (last_use[idx] < last_use[best]) begin
                            best = idx;
                        end
                    end
                    last_use[best]   = r.timestamp;
                    rsp.granted_slot = SLOT_W'(best);
                    rsp.evicted      = 1'b1;
                end
            end
            KIND_TOUCH, KIND_FREE: begin
                if (int'(r.slot) >= SLOTS || !in_use[r.slot]) begin
                    rsp.error = 1'b1;
                end else if (r.kind == KIND_TOUCH) begin
                    last_use[r.slot] = r.timestamp;
                end else begin
                    in_use[r.slot] = 1'b0;
                    free_slots++;
                end
            end
            default: ;
        endcase
        rsp.free_count = CNT_W'(free_slots);
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_pool();
            rsp_due.delete();
        end else begin
            // a response always belongs to an earlier request, so check first
            if (i_valid) begin
                if (rsp_due.size() == 0) begin
                    report("unexpected response, slot", int'(i_rsp.granted_slot), -1);
                end else begin
                    want = rsp_due.pop_front();
                    if (i_rsp.granted_slot !== want.granted_slot) begin
                        report("granted_slot", int'(i_rsp.granted_slot),
                               int'(want.granted_slot));
                    end
                    if (i_rsp.evicted !== want.evicted) begin
                        report("evicted", int'(i_rsp.evicted), int'(want.evicted));
                    end
                    if (i_rsp.free_count !== want.free_count) begin
                        report("free_count", int'(i_rsp.free_count), int'(want.free_count));
                    end
                    if (i_rsp.error !== want.error) begin
                        report("error", int'(i_rsp.error), int'(want.error));
                    end
                end
            end
            if (i_start && !i_busy) begin
                rsp_due.push_back(apply_request(i_req));
            end
        end
        o_pending    <= rsp_due.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for lru_slot_allocator: clock, reset, request stimulus and verdict.
// Depends on lru_pkg, lru_slot_allocator and lru_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lru_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int CHUNK_ITEMS  = 150;   // items per traffic mode
    localparam int STALL_LIMIT  = 1000;  // cycles with no transaction on either side
    localparam int DRAIN_CYCLES = SLOTS + 8;

    // traffic modes of the random part
    localparam int MODE_FILL  = 0;
    localparam int MODE_CHURN = 1;
    localparam int MODE_DRAIN = 2;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic             o_valid;
    t_req             req;
    t_rsp             rsp;
    int               pending;
    int               fail_count;

    // Stimulus-side view of which slots hold an allocation, so that touch and
    // free mostly name live slots. Alloc always lands on the lowest free slot
    // (or keeps the pool full on eviction), so this stays exact.
    logic [SLOTS-1:0] held;
    logic [TS_W-1:0]  wall_time;   // monotonic stamp source
    logic             idling;      // gaps enabled for the current chunk
    int               quiet_cycles;

    lru_slot_allocator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (req),
        .busy    (busy),
        .o_valid (o_valid),
        .o_rsp   (rsp)
    );

    lru_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (req),
        .i_valid      (o_valid),
        .i_rsp        (rsp),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Idle gap before a request: mostly none, some short, a few long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!idling || roll < 70) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end else if (roll < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Stamps: extremes, tiny values (to force ties on eviction), rising wall
    // time, and full-range noise.
    function automatic logic [TS_W-1:0] next_stamp();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return TS_W'($urandom_range(0, 7));
            4, 5, 6: begin
                wall_time = wall_time + TS_W'($urandom_range(1, 50));
                return wall_time;
            end
            default: return TS_W'($urandom);
        endcase
    endfunction

    // Random live slot; a random slot (an error case) if the pool is empty.
    function automatic logic [SLOT_W-1:0] pick_held();
        int base;
        int n;
        base = $urandom_range(0, SLOTS - 1);
        for (n = 0; n < SLOTS; n++) begin
            if (held[(base + n) % SLOTS]) begin
                return SLOT_W'((base + n) % SLOTS);
            end
        end
        return SLOT_W'(base);
    endfunction

    // Drives one request transaction and waits for it to be taken. Inputs move
    // on the falling edge; start is only lowered when a gap is wanted, so it
    // never gets two assignments in one time step.
    task automatic issue(t_kind kind, logic [SLOT_W-1:0] slot, logic [TS_W-1:0] ts);
        t_req r;
        int   gap;
        int   idx;
        logic placed;
        r.kind      = kind;
        r.slot      = slot;
        r.timestamp = ts;
        gap         = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        req   <= r;
        do @(posedge i_clk); while (busy);
        // keep the live-slot view in step with what was just accepted
        case (kind)
            KIND_ALLOC: begin
                placed = 1'b0;
                for (idx = 0; idx < SLOTS && !placed; idx++) begin
                    if (!held[idx]) begin
                        held[idx] = 1'b1;
                        placed    = 1'b1;
                    end
                end
            end
            KIND_FREE: held[slot] = 1'b0;
            default: ;
        endcase
    endtask

    // Sender-side stimulus. Reset is applied once, then a short directed run
    // over the corner cases, then mode-shaped random traffic.
    initial begin
        int   item;
        int   mode;
        int   roll;
        int   pct_alloc;
        int   pct_touch;
        int   pct_free;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        req       = '0;
        held      = '0;
        wall_time = '0;
        idling    = 1'b1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: no-op on an empty pool, touch/free of free slots (error),
        // allocs with extreme stamps, double free, and refill of the lowest slot.
        issue(KIND_NOP,   6'h3F, '1);
        issue(KIND_TOUCH, 6'h00, '0);
        issue(KIND_FREE,  6'h3F, '1);
        issue(KIND_ALLOC, 6'h3F, '1);
        issue(KIND_ALLOC, 6'h00, '0);
        issue(KIND_ALLOC, 6'h2A, 32'd5);
        issue(KIND_TOUCH, 6'h01, '1);
        issue(KIND_TOUCH, 6'h02, '0);
        issue(KIND_FREE,  6'h00, 32'hA5A5_5A5A);
        issue(KIND_FREE,  6'h00, 32'h5A5A_A5A5);
        issue(KIND_ALLOC, 6'h15, 32'h8000_0000);
        issue(KIND_TOUCH, 6'h3F, '1);
        issue(KIND_NOP,   6'h00, '0);
        issue(KIND_NOP,   6'h15, 32'h7FFF_FFFF);
        issue(KIND_FREE,  6'h02, '0);
        issue(KIND_FREE,  6'h01, '1);
        issue(KIND_FREE,  6'h00, '0);
        issue(KIND_FREE,  6'h20, '1);

        // Random: fill phases run the pool full so evictions (and stamp ties)
        // happen, churn mixes everything, drain empties it and then hits
        // free/touch of empty slots.
        for (item = 0; item < RANDOM_ITEMS; item++) begin
            if (item % CHUNK_ITEMS == 0) begin
                mode   = (item / CHUNK_ITEMS) % 3;
                idling = ($urandom_range(0, 9) > 2);
            end
            case (mode)
                MODE_FILL: begin
                    pct_alloc = 70; pct_touch = 15; pct_free = 5;
                end
                MODE_CHURN: begin
                    pct_alloc = 35; pct_touch = 30; pct_free = 25;
                end
                default: begin
                    pct_alloc = 10; pct_touch = 15; pct_free = 65;
                end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < pct_alloc) begin
                issue(KIND_ALLOC, SLOT_W'($urandom), next_stamp());
            end else if (roll < pct_alloc + pct_touch) begin
                issue(KIND_TOUCH, pick_held(), next_stamp());
            end else if (roll < pct_alloc + pct_touch + pct_free) begin
                issue(KIND_FREE, pick_held(), next_stamp());
            end else if (roll % 2 == 0) begin
                issue(KIND_NOP, SLOT_W'($urandom), next_stamp());
            end else begin
                // any slot at all: often a free one, so an error response
                issue(($urandom_range(0, 1) != 0) ? KIND_TOUCH : KIND_FREE,
                      SLOT_W'($urandom), next_stamp());
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        // let any stray response show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // Watchdog: ends the run if no transaction moves on either side for too
    // long. The slowest legal gap is a full-pool alloc, which reads every
    // slot's timestamp, plus the longest sender gap, far below the limit.
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (start && !busy) || o_valid) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("tb: errors");
        $finish;
    end

endmodule

// ===== lru_slot_allocator.f =====
rtl/lru_pkg.sv
rtl/lru_ts_ram.sv
rtl/lru_slot_allocator.sv
tb/sv/lru_checker.sv
tb/sv/tb.sv
